// File: hdl/pvt_pkg.sv
// shared types and constants for the peak and valley tracker
// no dependencies; imported by pvt_core and peak_valley_tracker_unit
`timescale 1ns / 1ps

package pvt_pkg;

    localparam int TEMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 8;
    localparam int COUNT_W = HOLD_W + 1;
    localparam int AMP_W   = TEMP_W + 1;

    localparam logic [HOLD_W-1:0]        HOLD_RESET = 8'd40;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 16'sh7fff;

    // one sample request after the input register
    typedef struct packed {
        logic [TIME_W-1:0]        sample_time;
        logic signed [TEMP_W-1:0] temperature;
    } sample_t;

    // one result item
    typedef struct packed {
        logic [TIME_W-1:0]       first_peak_time;
        logic [TIME_W-1:0]       period;
        logic signed [AMP_W-1:0] amplitude;
        logic                    valley_found;
        logic                    peak_found;
    } result_t;

    // tracker status seen by the top level
    typedef struct packed {
        logic [1:0] peaks_seen;
    } status_t;

endpackage

// File: hdl/peak_valley_tracker_unit.sv
// top level of the peak and valley tracker: stream ports, input and output registers
// depends on pvt_pkg and pvt_core
`timescale 1ns / 1ps

// Tracks a running maximum and minimum of a signed Q8.8 temperature stream and
// confirms a peak or valley once its candidate has gone hold_count samples without
// improvement. Each sample request yields exactly one result. Throughput is one
// sample per clock while the output is not stalled. The result becomes valid once
// its request has passed the input register and the single-pass update has been
// written into the output register. The tracker state advances only when the
// input register hands its sample to the output register, so a stalled output
// holds the state. hold_count is written on cfg_we and should change only while
// no request is in flight.
module peak_valley_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,      // hold_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // temperature[15:0], sample_time[47:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,       // amplitude[16:0], period[48:17],
                                       // first_peak_time[80:49], zero[87:81]
    output logic [1:0]  m_tuser        // peak_found[0], valley_found[1]
);
    import pvt_pkg::*;

    localparam int OUT_BITS = AMP_W + 2 * TIME_W;

    logic [HOLD_W-1:0] hold_reg;
    logic              in_valid_reg;
    sample_t           in_sample_reg;
    logic              out_valid_reg;
    result_t           out_result_reg;
    logic              advance;
    result_t           result;
    status_t           status;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            hold_reg <= cfg_data;
        end
    end

    // handshake: stage moves forward when the output is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_sample_reg.temperature <= s_tdata[TEMP_W-1:0];
            in_sample_reg.sample_time <= s_tdata[TEMP_W+TIME_W-1:TEMP_W];
        end
    end

    pvt_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .hold_count (hold_reg),
        .sample     (in_sample_reg),
        .result     (result),
        .status     (status)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_result_reg.valley_found, out_result_reg.peak_found};
    assign m_tdata  = {{(88 - OUT_BITS){1'b0}},
                       out_result_reg.first_peak_time,
                       out_result_reg.period,
                       out_result_reg.amplitude};

`ifndef SYNTHESIS
    // an empty input register always takes a request
    assert property (@(posedge clk) disable iff (!rst_n) !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // a held sample stays until the output side has room
    assert property (@(posedge clk) disable iff (!rst_n)
                     in_valid_reg && !advance |=> in_valid_reg)
        else $error("held sample lost");

    // a new result only appears after a processed sample
    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(m_tvalid) |-> $past(advance))
        else $error("result without a processed sample");

    // peak counter saturates at two
    assert property (@(posedge clk) disable iff (!rst_n) status.peaks_seen != 2'd3)
        else $error("peak counter overflow");
`endif

endmodule

// File: hdl/pvt_core.sv
// tracker state and the single-pass update for one sample
// depends on pvt_pkg
`timescale 1ns / 1ps

module pvt_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [pvt_pkg::HOLD_W-1:0]    hold_count,
    input  pvt_pkg::sample_t              sample,
    output pvt_pkg::result_t              result,
    output pvt_pkg::status_t              status
);
    import pvt_pkg::*;

    logic signed [TEMP_W-1:0] max_val_reg, max_val_next;
    logic [TIME_W-1:0]        max_time_reg, max_time_next;
    logic [COUNT_W-1:0]       max_cnt_reg, max_cnt_next;
    logic signed [TEMP_W-1:0] min_val_reg, min_val_next;
    logic [TIME_W-1:0]        min_time_reg, min_time_next;
    logic [COUNT_W-1:0]       min_cnt_reg, min_cnt_next;
    logic signed [TEMP_W-1:0] valley_val_reg, valley_val_next;
    logic signed [TEMP_W-1:0] peak_val_reg, peak_val_next;
    logic [TIME_W-1:0]        peak_time_reg, peak_time_next;
    logic [TIME_W-1:0]        prev_time_reg, prev_time_next;
    logic [TIME_W-1:0]        first_time_reg, first_time_next;
    logic [1:0]               seen_reg, seen_next;

    logic [COUNT_W-1:0] hold_ext;
    logic [COUNT_W-1:0] min_cnt_base;
    logic               peak;
    logic               valley;

    // saturating idle count step
    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] count,
                                                input logic [COUNT_W-1:0] hold);
        return (count <= hold) ? count + 1'b1 : count;
    endfunction

    assign hold_ext = {1'b0, hold_count};

    // maximum candidate and peak confirmation
    always_comb
    begin
        max_val_next    = max_val_reg;
        max_time_next   = max_time_reg;
        peak_val_next   = peak_val_reg;
        peak_time_next  = peak_time_reg;
        prev_time_next  = prev_time_reg;
        first_time_next = first_time_reg;
        seen_next       = seen_reg;
        min_cnt_base    = min_cnt_reg;
        if (sample.temperature > max_val_reg)
        begin
            max_val_next  = sample.temperature;
            max_time_next = sample.sample_time;
            max_cnt_next  = '0;
        end
        else
        begin
            max_cnt_next = bump(max_cnt_reg, hold_ext);
        end
        peak = (max_cnt_next == hold_ext);
        if (peak)
        begin
            if (seen_reg == 2'd0)
            begin
                first_time_next = max_time_next;
            end
            prev_time_next = peak_time_reg;
            peak_time_next = max_time_next;
            peak_val_next  = max_val_next;
            if (seen_reg != 2'd2)
            begin
                seen_next = seen_reg + 2'd1;
            end
            min_cnt_base  = '0;
            max_val_next  = sample.temperature;
            max_time_next = sample.sample_time;
        end
    end

    // minimum candidate and valley confirmation, after the peak clears its count
    always_comb
    begin
        min_val_next    = min_val_reg;
        min_time_next   = min_time_reg;
        valley_val_next = valley_val_reg;
        if (sample.temperature < min_val_reg)
        begin
            min_val_next  = sample.temperature;
            min_time_next = sample.sample_time;
            min_cnt_next  = '0;
        end
        else
        begin
            min_cnt_next = bump(min_cnt_base, hold_ext);
        end
        valley = (min_cnt_next == hold_ext);
        if (valley)
        begin
            valley_val_next = min_val_next;
            min_val_next    = sample.temperature;
            min_time_next   = sample.sample_time;
        end
    end

    // result from the updated state
    always_comb
    begin
        result.peak_found      = peak;
        result.valley_found    = valley;
        result.amplitude       = '0;
        result.period          = '0;
        result.first_peak_time = '0;
        if (seen_next != 2'd0)
        begin
            result.amplitude = {peak_val_next[TEMP_W-1], peak_val_next}
                             - {valley_val_next[TEMP_W-1], valley_val_next};
            result.first_peak_time = first_time_next;
        end
        if (seen_next == 2'd2)
        begin
            result.period = peak_time_next - prev_time_next;
        end
    end

    assign status.peaks_seen = seen_reg;

    // state registers, updated once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_val_reg    <= '0;
            max_time_reg   <= '0;
            max_cnt_reg    <= '0;
            min_val_reg    <= TEMP_MAX;
            min_time_reg   <= '0;
            min_cnt_reg    <= '0;
            valley_val_reg <= '0;
            peak_val_reg   <= '0;
            peak_time_reg  <= '0;
            prev_time_reg  <= '0;
            first_time_reg <= '0;
            seen_reg       <= '0;
        end
        else if (step)
        begin
            max_val_reg    <= max_val_next;
            max_time_reg   <= max_time_next;
            max_cnt_reg    <= max_cnt_next;
            min_val_reg    <= min_val_next;
            min_time_reg   <= min_time_next;
            min_cnt_reg    <= min_cnt_next;
            valley_val_reg <= valley_val_next;
            peak_val_reg   <= peak_val_next;
            peak_time_reg  <= peak_time_next;
            prev_time_reg  <= prev_time_next;
            first_time_reg <= first_time_next;
            seen_reg       <= seen_next;
        end
    end

endmodule
